// ----- rtl/core/swk_pkg.sv -----
package swk_pkg;

	// Field widths.
	localparam int VEL_W   = 12;
	localparam int COEF_W  = 16;
	localparam int SPEED_W = 13;
	localparam int ANG_W   = 12;

	// Fixed point: integers carry 16 fraction bits inside the datapath.
	localparam int FRAC_W = 16;
	// Signed wheel vector component and its magnitude.
	localparam int VEC_W  = 30;
	localparam int MAG_W  = 28;

	// Shared multiplier.
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;

	// Sum of squares and the part of it that sets the integer speed.
	localparam int SQ_W   = 57;
	localparam int SQI_W  = SQ_W - 2 * FRAC_W;

	// CORDIC datapath.
	localparam int CORD_W   = 34;
	localparam int Z_W      = 33;
	localparam int ATAN_W   = 31;
	localparam int STEPS    = 24;
	localparam int STEP_W   = 5;
	localparam int NORM_BIT = 29;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [ATAN_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [ATAN_W-1:0] a;
		case (i)
			5'd0:    a = 31'd536870912;
			5'd1:    a = 31'd316933406;
			5'd2:    a = 31'd167458907;
			5'd3:    a = 31'd85004756;
			5'd4:    a = 31'd42667331;
			5'd5:    a = 31'd21354465;
			5'd6:    a = 31'd10679838;
			5'd7:    a = 31'd5340245;
			5'd8:    a = 31'd2670163;
			5'd9:    a = 31'd1335087;
			5'd10:   a = 31'd667544;
			5'd11:   a = 31'd333772;
			5'd12:   a = 31'd166886;
			5'd13:   a = 31'd83443;
			5'd14:   a = 31'd41722;
			5'd15:   a = 31'd20861;
			5'd16:   a = 31'd10430;
			5'd17:   a = 31'd5215;
			5'd18:   a = 31'd2608;
			5'd19:   a = 31'd1304;
			5'd20:   a = 31'd652;
			5'd21:   a = 31'd326;
			5'd22:   a = 31'd163;
			5'd23:   a = 31'd81;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ----- rtl/core/swk_mul.sv -----
// Shared unsigned multiplier with a registered product.
module swk_mul import swk_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  op_a,
	input  logic [MUL_W-1:0]  op_b,
	output logic [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

// ----- rtl/core/swk_isqrt.sv -----
// Bit-serial integer square root, two radicand bits per cycle.
module swk_isqrt import swk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SQI_W-1:0]   radicand,
	output logic               busy,
	output logic [SPEED_W-1:0] root
);

	localparam int RW      = SQI_W + 1;
	localparam int NSTEP   = (SQI_W + 1) / 2;
	localparam int CNT_W   = $clog2(NSTEP);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SQI_W-1:0] rem_q;
	logic [RW-1:0]    res_q;
	logic [RW-1:0]    bit_q;
	logic [RW-1:0]    trial;
	logic             fits;

	assign trial = res_q + bit_q;
	assign fits  = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NSTEP - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= RW'(1) << (2 * (NSTEP - 1));
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial[SQI_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[SPEED_W-1:0];

endmodule

// ----- rtl/core/swk_cordic.sv -----
// Vectoring CORDIC: normalizes the vector one doubling per cycle, then
// runs one shift-add rotation per cycle and accumulates the angle.
module swk_cordic import swk_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [MAG_W-1:0]        x_in,
	input  logic signed [VEC_W-1:0] y_in,
	output logic                    busy,
	output logic signed [Z_W-1:0]   z
);

	typedef enum logic [1:0] {PH_IDLE, PH_NORM, PH_ROT} phase_t;

	localparam logic signed [CORD_W-1:0] NORM_POS = CORD_W'(1) <<< NORM_BIT;
	localparam logic signed [CORD_W-1:0] NORM_NEG = -NORM_POS;

	phase_t                    phase_q;
	logic [STEP_W-1:0]         step_q;
	logic signed [CORD_W-1:0]  x_q;
	logic signed [CORD_W-1:0]  y_q;
	logic signed [Z_W-1:0]     z_q;
	logic signed [CORD_W-1:0]  x_sh;
	logic signed [CORD_W-1:0]  y_sh;
	logic signed [Z_W-1:0]     atan_z;
	logic                      normed;

	assign x_sh   = x_q >>> step_q;
	assign y_sh   = y_q >>> step_q;
	assign atan_z = Z_W'(atan_turn(step_q));
	assign normed = (x_q >= NORM_POS) || (y_q >= NORM_POS) || (y_q <= NORM_NEG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_NORM;
					end
				end
				PH_NORM: begin
					if (normed) begin
						phase_q <= PH_ROT;
						step_q  <= '0;
					end
				end
				PH_ROT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(STEPS - 1)) begin
						phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && start) begin
			x_q <= CORD_W'(x_in);
			y_q <= CORD_W'(y_in);
			z_q <= '0;
		end else if (phase_q == PH_NORM && !normed) begin
			x_q <= x_q <<< 1;
			y_q <= y_q <<< 1;
		end else if (phase_q == PH_ROT) begin
			if (y_q > 0) begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_z;
			end else begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_z;
			end
		end
	end

	assign busy = (phase_q != PH_IDLE);
	assign z    = z_q;

endmodule

// ----- rtl/core/swerve_wheel_kinematics.sv -----
// Channel   Direction  Handshake                 Word
// in        input      in_valid / in_ready       vel_x, vel_y, vel_turn
// out       output     out_valid / out_ready     wheel_index, drive_dir, wheel_speed,
//                                                steer_angle, last_wheel
// cfg       input      cfg_wr_en (no wait)       cfg_index, cfg_data
//
// One input word yields four output words, wheel 0 to 3. The two rotation products
// are formed first. A wheel whose vector is zero goes straight to its output word;
// any other wheel waits on the CORDIC, which doubles the vector once a cycle until
// it is normalized and then rotates 24 times, while the square root runs beside it.
// The asynchronous reset returns the sequencer to idle and clears the held
// steering angles. in_ready is high only while the block is idle; each output
// word is held until it is taken, and a stall on out_ready freezes the sequence.
module swerve_wheel_kinematics import swk_pkg::*; #(
	parameter int COUNTS_PER_TURN = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [1:0]                cfg_index,
	input  logic [COEF_W-1:0]         cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [VEL_W-1:0]   vel_x,
	input  logic signed [VEL_W-1:0]   vel_y,
	input  logic signed [VEL_W-1:0]   vel_turn,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                wheel_index,
	output logic [1:0]                drive_dir,
	output logic [SPEED_W-1:0]        wheel_speed,
	output logic signed [ANG_W-1:0]   steer_angle,
	output logic                      last_wheel
);

	// Register map.
	localparam logic [1:0] REG_COS = 2'd0;
	localparam logic [1:0] REG_SIN = 2'd1;

	localparam logic [COEF_W-1:0] COS_RESET = 16'd38096;
	localparam logic [COEF_W-1:0] SIN_RESET = 16'd53327;

	// Drive direction codes.
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	localparam logic [1:0] LAST_WHEEL = 2'd3;

	// A pure sideways vector points exactly a quarter turn away; the count is
	// kept as its low bits when it does not fit the angle field.
	localparam int                QUARTER = COUNTS_PER_TURN / 4;
	localparam logic [ANG_W-1:0]  QTR_POS = ANG_W'(QUARTER);
	localparam logic [ANG_W-1:0]  QTR_NEG = ANG_W'(-QUARTER);
	localparam logic [MUL_W-1:0]  CPT_OP  = MUL_W'(COUNTS_PER_TURN);

	typedef enum logic [3:0] {
		S_IDLE, S_RC, S_RS, S_RSC, S_VEC, S_SQX, S_SQY, S_SUM,
		S_START, S_RUN, S_SCALE, S_ANG, S_OUT
	} state_t;

	state_t                    state_q;
	logic [1:0]                w_q;
	logic [COEF_W-1:0]         cos_q;
	logic [COEF_W-1:0]         sin_q;
	logic [ANG_W-1:0]          held_q [4];

	logic signed [VEL_W-1:0]   vx_q;
	logic signed [VEL_W-1:0]   vy_q;
	logic signed [VEL_W-1:0]   vw_q;
	logic signed [VEC_W-1:0]   rc_q;
	logic signed [VEC_W-1:0]   rs_q;
	logic [MAG_W-1:0]          ax_q;
	logic [MAG_W-1:0]          ay_q;
	logic signed [VEC_W-1:0]   ys_q;
	logic [SQ_W-1:0]           sq_q;
	logic [1:0]                dir_q;
	logic [SPEED_W-1:0]        speed_q;
	logic [ANG_W-1:0]          ang_q;

	// Shared multiplier operands and product.
	logic [MUL_W-1:0]          op_a;
	logic [MUL_W-1:0]          op_b;
	logic [PROD_W-1:0]         prod_q;

	// Square root and CORDIC.
	logic                      unit_start;
	logic                      sqrt_busy;
	logic [SPEED_W-1:0]        sqrt_root;
	logic                      cord_busy;
	logic signed [Z_W-1:0]     cord_z;

	// Wheel vector formed in S_VEC.
	logic [VEL_W-1:0]          vw_mag;
	logic signed [VEC_W-1:0]   rot_mag;
	logic signed [VEC_W-1:0]   vx_f;
	logic signed [VEC_W-1:0]   vy_f;
	logic signed [VEC_W-1:0]   x_c;
	logic signed [VEC_W-1:0]   y_c;
	logic signed [VEC_W-1:0]   x_n;
	logic signed [VEC_W-1:0]   y_n;
	logic                      x_neg;
	logic                      vec_zero;

	// Angle formed in S_ANG.
	logic [Z_W-1:0]            z_mag;
	logic [ANG_W-1:0]          scaled;
	logic [ANG_W-1:0]          ang_cord;
	logic [ANG_W-1:0]          ang_new;

	assign vw_mag  = vw_q[VEL_W-1] ? (~vw_q + 1'b1) : vw_q;
	assign rot_mag = prod_q[VEC_W-1:0];

	assign vx_f = {{(VEC_W-VEL_W-FRAC_W){vx_q[VEL_W-1]}}, vx_q, FRAC_W'(0)};
	assign vy_f = {{(VEC_W-VEL_W-FRAC_W){vy_q[VEL_W-1]}}, vy_q, FRAC_W'(0)};

	// Wheels 0 and 1 sit on the side where rotation subtracts from x; wheels 0
	// and 3 on the side where it adds to y.
	assign x_c = (w_q[1] == 1'b0) ? (vx_f - rc_q) : (vx_f + rc_q);
	assign y_c = (w_q == 2'd0 || w_q == 2'd3) ? (vy_f + rs_q) : (vy_f - rs_q);

	// A backward vector is flipped and driven in reverse, so the steering
	// target stays within a quarter turn of straight ahead.
	assign x_neg    = x_c[VEC_W-1];
	assign x_n      = x_neg ? -x_c : x_c;
	assign y_n      = x_neg ? -y_c : y_c;
	assign vec_zero = (x_c == '0) && (y_c == '0);

	// The CORDIC angle is in units of 2^-32 turn; scaling by counts per turn
	// and keeping the upper word truncates toward zero on the magnitude.
	assign z_mag    = cord_z[Z_W-1] ? -cord_z : cord_z;
	assign scaled   = prod_q[2*FRAC_W +: ANG_W];
	assign ang_cord = cord_z[Z_W-1] ? -scaled : scaled;

	always_comb begin
		if (ys_q == '0) begin
			ang_new = '0;
		end else if (ax_q == '0) begin
			ang_new = ys_q[VEC_W-1] ? QTR_NEG : QTR_POS;
		end else begin
			ang_new = ang_cord;
		end
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_RC: begin
				op_a = MUL_W'(vw_mag);
				op_b = MUL_W'(cos_q);
			end
			S_RS: begin
				op_a = MUL_W'(vw_mag);
				op_b = MUL_W'(sin_q);
			end
			S_SQX: begin
				op_a = MUL_W'(ax_q);
				op_b = MUL_W'(ax_q);
			end
			S_SQY: begin
				op_a = MUL_W'(ay_q);
				op_b = MUL_W'(ay_q);
			end
			S_SCALE: begin
				op_a = z_mag[MUL_W-1:0];
				op_b = CPT_OP;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign unit_start = (state_q == S_START);

	swk_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// Only the integer part of the sum of squares matters for the truncated
	// speed, so the root is taken of its upper bits.
	swk_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (unit_start),
		.radicand (sq_q[SQ_W-1 -: SQI_W]),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	swk_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.x_in   (ax_q),
		.y_in   (ys_q),
		.busy   (cord_busy),
		.z      (cord_z)
	);

	// Configuration registers; writes to an index beyond the map are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= COS_RESET;
			sin_q <= SIN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_COS: cos_q <= cfg_data;
				REG_SIN: sin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer with its control and held state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			w_q     <= '0;
			for (int i = 0; i < 4; i++) begin
				held_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RC;
					end
				end
				S_RC:    state_q <= S_RS;
				S_RS:    state_q <= S_RSC;
				S_RSC: begin
					state_q <= S_VEC;
					w_q     <= '0;
				end
				S_VEC:   state_q <= vec_zero ? S_OUT : S_SQX;
				S_SQX:   state_q <= S_SQY;
				S_SQY:   state_q <= S_SUM;
				S_SUM:   state_q <= S_START;
				S_START: state_q <= S_RUN;
				S_RUN: begin
					if (!sqrt_busy && !cord_busy) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: state_q <= S_ANG;
				S_ANG: begin
					state_q   <= S_OUT;
					held_q[w_q] <= ang_new;
				end
				S_OUT: begin
					if (out_ready) begin
						if (w_q == LAST_WHEEL) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_VEC;
							w_q     <= w_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					vx_q <= vel_x;
					vy_q <= vel_y;
					vw_q <= vel_turn;
				end
			end
			S_RS:  rc_q <= vw_q[VEL_W-1] ? -rot_mag : rot_mag;
			S_RSC: rs_q <= vw_q[VEL_W-1] ? -rot_mag : rot_mag;
			S_VEC: begin
				ax_q <= x_n[MAG_W-1:0];
				ys_q <= y_n;
				ay_q <= y_n[VEC_W-1] ? MAG_W'(-y_n) : y_n[MAG_W-1:0];
				if (vec_zero) begin
					dir_q   <= DIR_STOP;
					speed_q <= '0;
					ang_q   <= held_q[w_q];
				end else begin
					dir_q <= x_neg ? DIR_REV : DIR_FWD;
				end
			end
			S_SQY: sq_q <= prod_q[SQ_W-1:0];
			S_SUM: sq_q <= sq_q + prod_q[SQ_W-1:0];
			S_ANG: begin
				speed_q <= sqrt_root;
				ang_q   <= ang_new;
			end
			default: ;
		endcase
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign wheel_index = w_q;
	assign drive_dir   = dir_q;
	assign wheel_speed = speed_q;
	assign steer_angle = ang_q;
	assign last_wheel  = (w_q == LAST_WHEEL);

`ifndef SYNTHESIS
	// The block never takes a new command while a wheel word is pending.
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("in_ready and out_valid high together");

	// A stopped wheel reports zero speed.
	a_stop_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_dir == DIR_STOP |-> wheel_speed == '0)
		else $error("stopped wheel with nonzero speed");

	// Taking the fourth word returns the block to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_wheel |=> in_ready)
		else $error("not idle after the last wheel");

	// Taking any earlier word moves on to the next wheel.
	a_next_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_wheel |=>
		!in_ready && wheel_index == $past(wheel_index) + 2'd1)
		else $error("wheel sequence broken");
`endif

endmodule

// ----- sim/swerve_wheel_kinematics_tb.sv -----
module swerve_wheel_kinematics_tb;
	import swk_pkg::*;

	// Encoder counts per steering turn; the block is built with the same value.
	localparam int COUNTS_PER_TURN = 4096;
	localparam longint QUARTER_TURN = COUNTS_PER_TURN / 4;

	// Coefficient values after reset.
	localparam logic [COEF_W-1:0] COS_RESET = 16'd38096;
	localparam logic [COEF_W-1:0] SIN_RESET = 16'd53327;

	// Register map. Indexes two and three are not decoded and must be ignored.
	localparam logic [1:0] REG_COS_COEFF = 2'd0;
	localparam logic [1:0] REG_SIN_COEFF = 2'd1;
	localparam logic [1:0] REG_SPARE_2   = 2'd2;
	localparam logic [1:0] REG_SPARE_3   = 2'd3;

	// Drive direction codes.
	localparam logic [1:0] DIR_STOP    = 2'd0;
	localparam logic [1:0] DIR_FORWARD = 2'd1;
	localparam logic [1:0] DIR_REVERSE = 2'd2;

	// The vectoring pass first scales the vector up until its larger
	// component reaches this size.
	localparam longint NORM_LIMIT = 64'sd1 << NORM_BIT;

	// Arctangent of 2^-i, in units of 2^-32 turn.
	localparam longint ATAN_STEP [STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	// A generous wait after the last expected word, well above the worst case
	// for one command when the output never stalls.
	localparam int SETTLE_CYCLES = 300;
	// Length of the deliberate output stall that backs the block up.
	localparam int LONG_HOLD_CYCLES = 1500;

	typedef struct packed {
		logic [1:0]               wheel_index;
		logic [1:0]               drive_dir;
		logic [SPEED_W-1:0]       wheel_speed;
		logic signed [ANG_W-1:0]  steer_angle;
		logic                     last_wheel;
	} wheel_word_t;

	// The scoreboard keeps its own copy of the coefficients and of the held
	// steering angles, predicts the four wheel words of every accepted command
	// and matches them, in order, against the words the block delivers.
	class wheel_scoreboard;
		logic [COEF_W-1:0] cos_coeff;
		logic [COEF_W-1:0] sin_coeff;
		logic [ANG_W-1:0]  held_angle [4];
		wheel_word_t       wheel_q [$];
		int                errors;

		function new();
			cos_coeff = COS_RESET;
			sin_coeff = SIN_RESET;
			foreach (held_angle[w])
				held_angle[w] = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [COEF_W-1:0] data);
			if (idx == REG_COS_COEFF)
				cos_coeff = data;
			else if (idx == REG_SIN_COEFF)
				sin_coeff = data;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		function int pending();
			return wheel_q.size();
		endfunction

		// Integer square root, bit by bit.
		function longint unsigned root_floor(longint unsigned n);
			longint unsigned root;
			longint unsigned b;
			root = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= root + b) begin
					n -= root + b;
					root = (root >> 1) + b;
				end else begin
					root >>= 1;
				end
				b >>= 2;
			end
			return root;
		endfunction

		// Steering angle in counts for x >= 0 and a nonzero vector.
		function longint steer_counts(longint x, longint y);
			longint ay;
			longint m;
			longint z;
			longint nx;
			longint ny;
			longint a;
			if (y == 0)
				return 0;
			if (x == 0)
				return (y > 0) ? QUARTER_TURN : -QUARTER_TURN;
			ay = (y < 0) ? -y : y;
			m = (x > ay) ? x : ay;
			while (m < NORM_LIMIT) begin
				x = x * 2;
				y = y * 2;
				m = m * 2;
			end
			z = 0;
			for (int i = 0; i < STEPS; i++) begin
				if (y > 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z += ATAN_STEP[i];
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z -= ATAN_STEP[i];
				end
				x = nx;
				y = ny;
			end
			a = (z < 0) ? -z : z;
			a = (a * COUNTS_PER_TURN) >> 32;
			return (z < 0) ? -a : a;
		endfunction

		// Works out the four wheel words of one command.
		function void note_input(logic signed [VEL_W-1:0] vel_x,
				logic signed [VEL_W-1:0] vel_y, logic signed [VEL_W-1:0] vel_turn);
			longint vx;
			longint vy;
			longint rc;
			longint rs;
			longint x;
			longint y;
			longint ang;
			longint unsigned ux;
			longint unsigned uy;
			wheel_word_t r;
			vx = longint'(vel_x) * 65536;
			vy = longint'(vel_y) * 65536;
			rc = longint'(vel_turn) * longint'(cos_coeff);
			rs = longint'(vel_turn) * longint'(sin_coeff);
			for (int w = 0; w < 4; w++) begin
				x = (w < 2) ? vx - rc : vx + rc;
				y = (w == 0 || w == 3) ? vy + rs : vy - rs;
				if (x < 0) begin
					r.drive_dir = DIR_REVERSE;
					x = -x;
					y = -y;
				end else if (x > 0 || y != 0) begin
					r.drive_dir = DIR_FORWARD;
				end else begin
					r.drive_dir = DIR_STOP;
				end
				if (x == 0 && y == 0) begin
					// A stopped wheel keeps pointing where it last pointed.
					r.wheel_speed = '0;
					r.steer_angle = held_angle[w];
				end else begin
					ux = x;
					uy = (y < 0) ? -y : y;
					r.wheel_speed = SPEED_W'(root_floor(ux * ux + uy * uy) >> FRAC_W);
					ang = steer_counts(x, y);
					r.steer_angle = ang[ANG_W-1:0];
					held_angle[w] = ang[ANG_W-1:0];
				end
				r.wheel_index = w[1:0];
				r.last_wheel = (w == 3);
				wheel_q.push_back(r);
			end
		endfunction

		task check_result(wheel_word_t got);
			wheel_word_t want;
			if (wheel_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word %p", got));
			end else begin
				want = wheel_q.pop_front();
				if (got.wheel_index !== want.wheel_index)
					report_mismatch($sformatf("wheel_index %0d, want %0d",
						got.wheel_index, want.wheel_index));
				if (got.drive_dir !== want.drive_dir)
					report_mismatch($sformatf("wheel %0d drive_dir %0d, want %0d",
						want.wheel_index, got.drive_dir, want.drive_dir));
				if (got.wheel_speed !== want.wheel_speed)
					report_mismatch($sformatf("wheel %0d wheel_speed %0d, want %0d",
						want.wheel_index, got.wheel_speed, want.wheel_speed));
				if (got.steer_angle !== want.steer_angle)
					report_mismatch($sformatf("wheel %0d steer_angle %0d, want %0d",
						want.wheel_index, got.steer_angle, want.steer_angle));
				if (got.last_wheel !== want.last_wheel)
					report_mismatch($sformatf("wheel %0d last_wheel %0b, want %0b",
						want.wheel_index, got.last_wheel, want.last_wheel));
			end
		endtask
	endclass

	// Every input of the block starts at a known value.
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr_en = 1'b0;
	logic [1:0]                cfg_index = '0;
	logic [COEF_W-1:0]         cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [VEL_W-1:0]   vel_x = '0;
	logic signed [VEL_W-1:0]   vel_y = '0;
	logic signed [VEL_W-1:0]   vel_turn = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [1:0]                wheel_index;
	logic [1:0]                drive_dir;
	logic [SPEED_W-1:0]        wheel_speed;
	logic signed [ANG_W-1:0]   steer_angle;
	logic                      last_wheel;

	// Idle rates, in percent of cycles, for the command and wheel sides.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// The stimulus asks for a long output stall by bumping hold_req; the
	// receiver process notices the change, serves it and counts the stall out.
	int hold_req = 0;
	int hold_served = 0;
	int hold_left = 0;

	wheel_scoreboard sb;

	swerve_wheel_kinematics #(
		.COUNTS_PER_TURN(COUNTS_PER_TURN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.vel_turn(vel_turn),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.wheel_index(wheel_index),
		.drive_dir(drive_dir),
		.wheel_speed(wheel_speed),
		.steer_angle(steer_angle),
		.last_wheel(last_wheel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Wheel side. out_ready changes only at rising edges. A pending long hold
	// request takes priority over the random idling of the current phase.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_req) begin
			out_ready <= 1'b0;
			hold_served <= hold_req;
			hold_left <= LONG_HOLD_CYCLES;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Output monitor. Sampling at the falling edge sees settled values; a word
	// offered with out_ready high here is taken at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{wheel_index, drive_dir, wheel_speed, steer_angle, last_wheel});
	end

	// Velocity field generator: mostly the full range, with a good share of
	// extremes, zeros and small values so that sums cancel now and then.
	function automatic logic signed [VEL_W-1:0] rand_vel();
		logic [VEL_W-1:0] v;
		v = VEL_W'($urandom);
		case ($urandom_range(9))
			0: v = 12'h800;
			1: v = 12'h7FF;
			2: v = '0;
			3, 4: v = VEL_W'($urandom_range(16) - 8);
			default: ;
		endcase
		return v;
	endfunction

	// Offers one command word and returns at the edge that accepts it. in_valid
	// is left high so the next call can keep it up without a glitch; the caller
	// lowers it when it stops sending.
	task automatic send_word(input int x, input int y, input int t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		vel_x <= VEL_W'(x);
		vel_y <= VEL_W'(y);
		vel_turn <= VEL_W'(t);
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		sb.note_input(VEL_W'(x), VEL_W'(y), VEL_W'(t));
	endtask

	task automatic send_random(input int count);
		repeat (count)
			send_word(int'(rand_vel()), int'(rand_vel()), int'(rand_vel()));
	endtask

	// One register write per cycle; the enable stays up across a burst.
	task automatic write_reg(input logic [1:0] idx, input logic [COEF_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Writes both coefficients and, if asked, junk to the undecoded indexes.
	task automatic write_coeffs(input logic [COEF_W-1:0] c, input logic [COEF_W-1:0] s,
			input bit with_spares);
		write_reg(REG_COS_COEFF, c);
		write_reg(REG_SIN_COEFF, s);
		if (with_spares) begin
			write_reg(REG_SPARE_2, COEF_W'($urandom));
			write_reg(REG_SPARE_3, COEF_W'($urandom));
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Stops sending and waits until every predicted word has come back, then
	// lets the block settle. Configuration changes only follow this.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: reset coefficients, directed commands, sender idles
		// lightly and the wheel side heavily.
		send_idle_pct <= 26;
		recv_idle_pct <= 62;
		// All wheels stopped straight out of reset hold angle zero.
		send_word(0, 0, 0);
		send_word(2047, 2047, 2047);
		send_word(-2048, -2048, -2048);
		send_word(2047, -2048, 0);
		send_word(-2048, 2047, 0);
		// Pure sideways vectors give exactly a quarter turn either way, and a
		// stop right after must hold that quarter turn.
		send_word(0, 100, 0);
		send_word(0, -100, 0);
		send_word(0, 0, 0);
		// Straight ahead and straight back give angle zero.
		send_word(100, 0, 0);
		send_word(-100, 0, 0);
		send_word(0, 0, 2047);
		send_word(0, 0, -2048);
		send_word(1, 1, 0);
		send_word(-1, -1, 0);
		send_word(1, -1, 0);
		send_word(2047, 0, -2048);
		send_word(0, 2047, 1);
		drain();

		// Phase two: zero coefficients, so rotation has no effect at all.
		write_coeffs('0, '0, 1'b1);
		send_word(0, 0, 5);
		send_word(7, -3, 2047);
		send_random(35);
		drain();

		// Phase three: largest coefficients, idle rates swapped, and a long
		// stall on the wheel side while commands keep coming.
		send_idle_pct <= 62;
		recv_idle_pct <= 26;
		write_coeffs(16'hFFFF, 16'hFFFF, 1'b0);
		send_word(2047, 2047, 2047);
		send_word(-2048, -2048, 2047);
		hold_req <= hold_req + 1;
		send_random(35);
		drain();

		// Phase four: half coefficients, where chosen commands cancel single
		// wheels exactly; no idling on either side.
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		write_coeffs(16'h8000, 16'h8000, 1'b1);
		// Wheel 0 ends up sideways and wheel 1 stops, holding its old angle.
		send_word(3, 3, 6);
		// Wheel 0 stops and wheel 1 ends up sideways.
		send_word(-3, 3, -6);
		send_random(35);
		drain();

		// Phase five: random coefficients.
		write_coeffs(COEF_W'($urandom), COEF_W'($urandom), 1'b1);
		send_random(35);
		drain();

		if (sb.errors == 0)
			$display("[swerve_wheel_kinematics] OK");
		else
			$display("[swerve_wheel_kinematics] ERROR");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#5000000;
		$display("[swerve_wheel_kinematics] ERROR");
		$finish;
	end

endmodule
